// File: rtl/core/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_table, pps_select and preemptive_priority_scheduler.
`timescale 1ns / 1ps

package pps_pkg;

   localparam int TIME_W  = 24;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int SLOT_W  = 4;

   localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;

   // request kinds carried on req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [PRIO_W-1:0]  priority_level;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
   } slot_rec_type;

   typedef struct packed {
      logic live;      // remaining work is nonzero
      logic started;   // slot has had its first service
   } slot_flags_type;

   // time + 1, held at the top of the range
   function automatic logic [TIME_W-1:0] time_inc(input logic [TIME_W-1:0] t);
      return (t == TIME_MAX) ? t : t + 24'd1;
   endfunction

endpackage

// File: rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler, top level: request sequencer, timing math and
// response register. Depends on pps_pkg, pps_table and pps_select.
//
// Usage:
//   req channel: tuser = opcode (0 load, 1 tick); tdata = slot_id, arrival_time,
//   burst_length, priority_level from bit 0 up. A load writes one slot in the
//   cycle it is accepted and returns nothing; it is ready again next cycle.
//   A tick scans all MAX_PROCESSES slots, one per cycle, through a single
//   compare unit fed from the slot memory's read port, then drains the read
//   pipe (S_DRAIN) and does the update and the time arithmetic in S_RUN,
//   S_TAT, S_WAIT and S_OUT. rsp_tvalid is registered out of S_OUT, and
//   req_tready is low from an accepted tick until then, so the next request
//   is taken only once the tick is through.
//   rsp channel: tuser = ran_valid, first_run, finished; tdata = ran_slot,
//   response, completion, turnaround and waiting times. One response per tick.
//   The response sits in an output register; a new request is taken while it
//   waits, and a following tick holds in its last step until rsp_tready frees
//   the register.
//   Reset (synchronous) clears time to zero and marks every slot empty and
//   not started; slot records need no clearing.
`timescale 1ns / 1ps

module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int MAX_PROCESSES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,   // slot_id[3:0], arrival_time[19:4],
                                      // burst_length[35:20], priority_level[43:36]
   input  logic          req_tuser,   // opcode[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // ran_slot[3:0], response_time[27:4],
                                      // completion_time[51:28],
                                      // turnaround_time[75:52], waiting_time[99:76]
   output logic [2:0]    rsp_tuser    // ran_valid[0], first_run[1], finished[2]
);

   localparam int IDX_W = $clog2(MAX_PROCESSES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DRAIN, S_RUN, S_TAT, S_WAIT, S_OUT
   } state_type;

   // request fields
   logic [SLOT_W-1:0]  req_slot_id;
   logic [ARR_W-1:0]   req_arrival;
   logic [BURST_W-1:0] req_burst;
   logic [PRIO_W-1:0]  req_prio;

   assign req_slot_id = req_tdata[3:0];
   assign req_arrival = req_tdata[19:4];
   assign req_burst   = req_tdata[35:20];
   assign req_prio    = req_tdata[43:36];

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [IDX_W-1:0]   issue_ff, issue_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               first_ff, first_in;
   logic               fin_ff, fin_in;
   logic [TIME_W-1:0]  resp_ff, resp_in;
   logic [TIME_W-1:0]  comp_ff, comp_in;
   logic [TIME_W-1:0]  tat_ff, tat_in;
   logic [TIME_W-1:0]  wait_ff, wait_in;
   logic               run_ff, run_in;
   logic [SLOT_W-1:0]  run_slot_ff, run_slot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_user_ff, rsp_user_in;
   logic [103:0]       rsp_data_ff, rsp_data_in;

   logic               req_acc, is_load, is_tick, slot_ok, out_free, sel_start;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_rec_type       wr_rec, rd_rec, best_rec;
   slot_flags_type     wr_flags, rd_flags;
   logic               best_found, best_started;
   logic [IDX_W-1:0]   best_idx;
   logic [TIME_W-1:0]  arr_ext, burst_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_load    = req_acc && (req_tuser == OP_LOAD);
   assign is_tick    = req_acc && (req_tuser == OP_TICK);
   assign slot_ok    = (32'(req_slot_id) < MAX_PROCESSES);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sel_start  = is_tick;
   assign arr_ext    = {{(TIME_W-ARR_W){1'b0}}, best_rec.arrival};
   assign burst_ext  = {{(TIME_W-BURST_W){1'b0}}, best_rec.burst};

   // single write port: loads from idle, remaining-count update after a scan
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = best_idx;
      wr_rec   = best_rec;
      wr_flags = '0;
      if (is_load) begin
         wr_en                 = slot_ok;
         wr_addr               = IDX_W'(req_slot_id);
         wr_rec.arrival        = req_arrival;
         wr_rec.priority_level = req_prio;
         wr_rec.burst          = req_burst;
         wr_rec.remaining      = req_burst;
         wr_flags.live         = (req_burst != '0);
         wr_flags.started      = 1'b0;
      end else if (state_ff == S_RUN) begin
         wr_en            = best_found;
         wr_rec.remaining = best_rec.remaining - 16'd1;
         wr_flags.live    = (best_rec.remaining != 16'd1);
         wr_flags.started = 1'b1;
      end
   end

   pps_table #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_rec   (wr_rec),
      .wr_flags (wr_flags),
      .rd_addr  (issue_ff),
      .rd_rec   (rd_rec),
      .rd_flags (rd_flags)
   );

   pps_select #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .start        (sel_start),
      .cand_valid   (rd_vld_ff),
      .cand_idx     (rd_idx_ff),
      .cand_rec     (rd_rec),
      .cand_flags   (rd_flags),
      .cur_time     (time_ff),
      .best_found   (best_found),
      .best_idx     (best_idx),
      .best_rec     (best_rec),
      .best_started (best_started)
   );

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      issue_in     = issue_ff;
      rd_vld_in    = (state_ff == S_SCAN);
      rd_idx_in    = issue_ff;
      first_in     = first_ff;
      fin_in       = fin_ff;
      resp_in      = resp_ff;
      comp_in      = comp_ff;
      tat_in       = tat_ff;
      wait_in      = wait_ff;
      run_in       = run_ff;
      run_slot_in  = run_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            issue_in = '0;
            if (is_tick) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            issue_in = issue_ff + IDX_W'(1);
            if (issue_ff == LAST_IDX) begin
               issue_in = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            run_in      = best_found;
            run_slot_in = SLOT_W'(best_idx);
            first_in    = best_found && !best_started;
            fin_in      = best_found && (best_rec.remaining == 16'd1);
            resp_in     = (best_found && !best_started) ? (time_ff - arr_ext) : '0;
            comp_in     = time_inc(time_ff);
            state_in    = S_TAT;
         end
         S_TAT: begin
            tat_in   = comp_ff - arr_ext;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            // saturated time can leave turnaround below the burst
            wait_in  = (tat_ff >= burst_ext) ? (tat_ff - burst_ext) : '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {fin_ff, first_ff, run_ff};
               rsp_data_in  = {4'd0,
                               fin_ff ? wait_ff : 24'd0,
                               fin_ff ? tat_ff  : 24'd0,
                               fin_ff ? comp_ff : 24'd0,
                               resp_ff,
                               run_ff ? run_slot_ff : 4'd0};
               time_in      = time_inc(time_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      first_ff    <= first_in;
      fin_ff      <= fin_in;
      resp_ff     <= resp_in;
      comp_ff     <= comp_in;
      tat_ff      <= tat_in;
      wait_ff     <= wait_in;
      run_ff      <= run_in;
      run_slot_ff <= run_slot_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/pps_table.sv
// Process slot table: record memory with one write and one registered read port,
// plus live/started flags in flops cleared by reset. Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_table
   import pps_pkg::*;
#(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_PROCESSES)-1:0] wr_addr,
   input  slot_rec_type                     wr_rec,
   input  slot_flags_type                   wr_flags,
   input  logic [$clog2(MAX_PROCESSES)-1:0] rd_addr,
   output slot_rec_type                     rd_rec,
   output slot_flags_type                   rd_flags
);

   slot_rec_type   mem [MAX_PROCESSES];
   slot_flags_type flags_ff [MAX_PROCESSES];
   slot_rec_type   rd_rec_ff;
   slot_flags_type rd_flags_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_rec;
      end
      rd_rec_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCESSES; i++) begin
            flags_ff[i] <= '0;
         end
         rd_flags_ff <= '0;
      end else begin
         if (wr_en) begin
            flags_ff[wr_addr] <= wr_flags;
         end
         rd_flags_ff <= flags_ff[rd_addr];
      end
   end

   assign rd_rec   = rd_rec_ff;
   assign rd_flags = rd_flags_ff;

endmodule

// File: rtl/core/pps_select.sv
// Shared compare unit: takes one slot per cycle and keeps the best candidate
// (priority, then remaining burst, then lower index). Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_select
   import pps_pkg::*;
#(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             cand_valid,
   input  logic [$clog2(MAX_PROCESSES)-1:0] cand_idx,
   input  slot_rec_type                     cand_rec,
   input  slot_flags_type                   cand_flags,
   input  logic [TIME_W-1:0]                cur_time,
   output logic                             best_found,
   output logic [$clog2(MAX_PROCESSES)-1:0] best_idx,
   output slot_rec_type                     best_rec,
   output logic                             best_started
);

   localparam int IDX_W = $clog2(MAX_PROCESSES);

   logic             found_ff, found_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   slot_rec_type     rec_ff, rec_in;
   logic             started_ff, started_in;
   logic             eligible, better;

   // slots come in ascending order, so a strict win keeps the lower index on ties
   always_comb begin
      eligible = cand_valid && cand_flags.live &&
                 ({{(TIME_W-ARR_W){1'b0}}, cand_rec.arrival} <= cur_time);
      better   = !found_ff ||
                 (cand_rec.priority_level < rec_ff.priority_level) ||
                 ((cand_rec.priority_level == rec_ff.priority_level) &&
                  (cand_rec.remaining < rec_ff.remaining));
      found_in   = found_ff;
      idx_in     = idx_ff;
      rec_in     = rec_ff;
      started_in = started_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (eligible && better) begin
         found_in   = 1'b1;
         idx_in     = cand_idx;
         rec_in     = cand_rec;
         started_in = cand_flags.started;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff     <= idx_in;
      rec_ff     <= rec_in;
      started_ff <= started_in;
   end

   assign best_found   = found_ff;
   assign best_idx     = idx_ff;
   assign best_rec     = rec_ff;
   assign best_started = started_ff;

endmodule
